// ===== rtl/core/weighted_topk_accuracy_map_macros.svh =====
// Assertion macros for the weighted top-k accuracy block.
// Used by the port checker; relies on clk and rst_n in the calling scope.
`ifndef WEIGHTED_TOPK_ACCURACY_MAP_MACROS_SVH
`define WEIGHTED_TOPK_ACCURACY_MAP_MACROS_SVH

// same-cycle implication, disabled in reset
`define WTAM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WTAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wtam_pkg.sv =====
// Shared types and constants of the weighted top-k accuracy block.
// No dependencies.
package wtam_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TOP_K_W    = 9;
  localparam int unsigned NIMG_W     = 16;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned DCNT_W     = 6;

  localparam logic [CFG_ADDR_W-1:0] REG_TOP_K      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_IMAGES = 2'd1;

  typedef struct packed {
    logic signed [31:0] score;
    logic [7:0]         gt_label;
    logic signed [31:0] pixel_weight;
    logic               last_class;
    logic               last_pixel;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] accuracy;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic store;
    logic rd_ref;
    logic cap_ref;
    logic scan_start;
    logic scan;
    logic acc;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last_pixel;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/wtam_ctrl.sv =====
// Sequencer of the weighted top-k accuracy block.
// Depends on wtam_pkg for the command and status structs.
module wtam_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_class,
  output logic          in_ready,
  input  wtam_pkg::sts_t sts,
  output wtam_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_REF   = 8'b0000_0010,
    S_REFW  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_DINIT = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.store = accept;
        if (accept && in_last_class) begin
          state_nxt = S_REF;
        end
      end
      S_REF: begin
        cmd.rd_ref = 1'b1;
        state_nxt  = S_REFW;
      end
      S_REFW: begin
        cmd.cap_ref    = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_pixel ? S_DINIT : S_IDLE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/wtam_dp.sv =====
// Datapath of the weighted top-k accuracy block: score buffer, rank scan,
// saturating accumulator, bit-serial divider and output register.
// Depends on wtam_pkg.
module wtam_dp #(
  parameter int unsigned MAX_CLASSES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wtam_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [wtam_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [wtam_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wtam_pkg::cmd_t                    cmd,
  output wtam_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wtam_pkg::out_item_t               out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_CLASSES);
  localparam int unsigned LBL_W = CNT_W + 8;
  localparam int unsigned CMP_W = (CNT_W > wtam_pkg::TOP_K_W) ? CNT_W : wtam_pkg::TOP_K_W;
  localparam int unsigned SUM_W = wtam_pkg::SUM_W;
  localparam int unsigned NIM_W = wtam_pkg::NIMG_W;

  logic signed [31:0] mem [MAX_CLASSES];

  logic [wtam_pkg::TOP_K_W-1:0] top_k_r;
  logic [NIM_W-1:0]             num_images_r;

  logic [CNT_W-1:0]   count_r;
  logic [7:0]         label_r;
  logic signed [31:0] weight_r;
  logic               lp_r;

  logic signed [31:0] rd_data_r;
  logic signed [31:0] ref_r;
  logic [IDX_W-1:0]   rd_addr;

  logic [CNT_W-1:0]   issue_r;
  logic               pend_r;
  logic [IDX_W-1:0]   pend_idx_r;
  logic [CNT_W-1:0]   beaters_r;

  logic signed [SUM_W-1:0] hit_sum_r;
  logic                    ovf_r;

  logic [SUM_W-1:0]   quo_r;
  logic [NIM_W-1:0]   rem_r;
  logic [NIM_W-1:0]   divisor_r;
  logic [wtam_pkg::DCNT_W-1:0] dcnt_r;
  logic               neg_r;
  logic               sat_r;

  logic                    out_valid_r;
  wtam_pkg::out_item_t     out_data_r;

  logic                    full;
  logic [LBL_W-1:0]        lbl_wide;
  logic                    lbl_ok;
  logic                    beats;
  logic                    hit;
  logic signed [SUM_W:0]   sum_ext;
  logic                    sum_ovf;
  logic signed [SUM_W-1:0] sum_sat;
  logic [NIM_W:0]          rem_sh;
  logic                    ge;
  logic [NIM_W:0]          rem_sub;
  logic                    pos_over;
  logic                    neg_over;
  logic [31:0]             q32;
  wtam_pkg::out_item_t     res;

  assign full     = (count_r == CNT_W'(MAX_CLASSES));
  assign lbl_wide = LBL_W'(label_r);
  assign lbl_ok   = lbl_wide < LBL_W'(count_r);
  assign beats    = (rd_data_r > ref_r) ||
                    ((rd_data_r == ref_r) && (LBL_W'(pend_idx_r) > lbl_wide));
  assign hit      = lbl_ok && (top_k_r != '0) && (CMP_W'(beaters_r) < CMP_W'(top_k_r));
  assign rd_addr  = cmd.rd_ref ? lbl_wide[IDX_W-1:0] : issue_r[IDX_W-1:0];

  assign sum_ext  = (SUM_W+1)'(hit_sum_r) + (SUM_W+1)'(weight_r);
  assign sum_ovf  = sum_ext[SUM_W] != sum_ext[SUM_W-1];
  assign sum_sat  = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};

  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor_r};
  assign rem_sub  = rem_sh - {1'b0, divisor_r};

  assign pos_over = !neg_r && (quo_r > SUM_W'(32'h7FFF_FFFF));
  assign neg_over = neg_r && (quo_r > SUM_W'(32'h8000_0000));
  assign q32      = neg_r ? (32'd0 - quo_r[31:0]) : quo_r[31:0];

  always_comb begin
    res.saturated = sat_r || pos_over || neg_over;
    if (pos_over) begin
      res.accuracy = 32'sh7FFF_FFFF;
    end else if (neg_over) begin
      res.accuracy = 32'sh8000_0000;
    end else begin
      res.accuracy = q32;
    end
  end

  assign sts.scan_done  = (issue_r == count_r) && !pend_r;
  assign sts.last_pixel = lp_r;
  assign sts.div_last   = (dcnt_r == wtam_pkg::DCNT_W'(1));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem[count_r[IDX_W-1:0]] <= in_data.score;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_k_r      <= wtam_pkg::TOP_K_W'(1);
      num_images_r <= NIM_W'(1);
    end else if (cfg_we) begin
      if (cfg_addr == wtam_pkg::REG_TOP_K) begin
        top_k_r <= cfg_wdata[wtam_pkg::TOP_K_W-1:0];
      end
      if (cfg_addr == wtam_pkg::REG_NUM_IMAGES) begin
        num_images_r <= cfg_wdata[NIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      hit_sum_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store && !full) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        pend_r <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= (issue_r != count_r);
      end
      if (cmd.acc) begin
        count_r <= '0;
        if (hit) begin
          hit_sum_r <= sum_ovf ? sum_sat : sum_ext[SUM_W-1:0];
          ovf_r     <= ovf_r || sum_ovf;
        end
      end
      if (cmd.div_init) begin
        hit_sum_r <= '0;
        ovf_r     <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      label_r  <= in_data.gt_label;
      weight_r <= in_data.pixel_weight;
      lp_r     <= in_data.last_pixel;
    end
    if (cmd.cap_ref) begin
      ref_r <= rd_data_r;
    end
    if (cmd.scan_start) begin
      issue_r   <= '0;
      beaters_r <= '0;
    end else if (cmd.scan) begin
      if (issue_r != count_r) begin
        issue_r <= issue_r + CNT_W'(1);
      end
      pend_idx_r <= issue_r[IDX_W-1:0];
      if (pend_r && beats) begin
        beaters_r <= beaters_r + CNT_W'(1);
      end
    end
    if (cmd.div_init) begin
      neg_r     <= hit_sum_r[SUM_W-1];
      quo_r     <= hit_sum_r[SUM_W-1] ? (SUM_W'(0) - hit_sum_r) : hit_sum_r;
      rem_r     <= '0;
      dcnt_r    <= wtam_pkg::DCNT_W'(SUM_W);
      divisor_r <= (num_images_r == '0) ? NIM_W'(1) : num_images_r;
      sat_r     <= ovf_r;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? rem_sub[NIM_W-1:0] : rem_sh[NIM_W-1:0];
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      dcnt_r <= dcnt_r - wtam_pkg::DCNT_W'(1);
    end
    if (cmd.load_out) begin
      out_data_r <= res;
    end
  end

endmodule

// ===== rtl/core/weighted_topk_accuracy_map.sv =====
// Weighted top-k accuracy block, top level.
// Depends on wtam_pkg, wtam_ctrl and wtam_dp.
//
// Input channel in_*: one beat per class score, classes in index order; the
// beat with last_class closes the pixel and supplies its label and weight.
// A beat with last_class and last_pixel closes the batch and yields one
// result beat on out_*; all other beats yield none.
// Configuration cfg_*: index 0 is top_k, index 1 is num_images; write only
// while the block is idle.
// Throughput: score beats are taken one per cycle while in_ready is high.
// The rank scan of each pixel reads the score buffer one entry per cycle
// through its single read port, and in_ready stays low meanwhile, so the
// block takes no new scores while a pixel is being ranked.
// Order after the scan of the last pixel ends: the accumulate step, the
// divider load, 48 divider steps at one quotient bit per cycle, and the
// load of the output register, which waits until the output is free.
// The result sits in an output register; a stalled receiver holds it, and
// the block keeps taking the next batch's scores. A new result waits until
// the previous one has been taken.
// Reset: top_k and num_images return to 1, the accumulator and class count
// clear, and no result is pending. The score buffer is not cleared.
module weighted_topk_accuracy_map #(
  parameter int unsigned MAX_CLASSES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wtam_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wtam_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [wtam_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wtam_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  wtam_pkg::cmd_t cmd;
  wtam_pkg::sts_t sts;

  wtam_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_class (in_data.last_class),
    .in_ready      (in_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  wtam_dp #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/wtam_checker.sv =====
// Port-level checker of the weighted top-k accuracy block, bound to the top.
// Depends on wtam_pkg and weighted_topk_accuracy_map_macros.svh.
`include "weighted_topk_accuracy_map_macros.svh"

module wtam_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input wtam_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input wtam_pkg::out_item_t out_data
);

  `WTAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")
  `WTAM_ASSERT_IMPL(a_out_reset, $past(!rst_n), !out_valid, "result beat pending right after reset")
  `WTAM_ASSERT_NEXT(a_pixel_busy, in_valid && in_ready && in_data.last_class, !in_ready, "input taken during rank scan")

endmodule

bind weighted_topk_accuracy_map wtam_checker u_wtam_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb_weighted_topk_accuracy_map.sv =====
// Self-checking testbench for weighted_topk_accuracy_map: directed and random
// pixel batches over valid/ready, checked against a scoreboard class.
// Depends on wtam_pkg and the weighted_topk_accuracy_map RTL.
`timescale 1ns / 100ps

module tb_weighted_topk_accuracy_map;

  localparam int MAX_CLASSES = 256;
  localparam int HOLD_CYCLES = 2 * MAX_CLASSES + 80;
  localparam int S_MIN = 32'sh8000_0000;
  localparam int S_MAX = 32'sh7FFF_FFFF;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  class topk_accuracy_tracker;
    logic signed [31:0] class_scores [MAX_CLASSES];
    int unsigned n_buffered;
    longint weighted_sum;
    bit sum_clipped;
    int unsigned top_k;
    int unsigned num_images;
    wtam_pkg::out_item_t pending_accuracy[$];
    int errors;

    function new();
      n_buffered = 0;
      weighted_sum = 0;
      sum_clipped = 0;
      top_k = 1;
      num_images = 1;
      errors = 0;
    endfunction

    function void set_reg(logic [wtam_pkg::CFG_ADDR_W-1:0] idx, int unsigned val);
      if (idx == wtam_pkg::REG_TOP_K) top_k = val & 'h1FF;
      else if (idx == wtam_pkg::REG_NUM_IMAGES) num_images = val & 'hFFFF;
    endfunction

    function void take_score(wtam_pkg::in_item_t it);
      int unsigned beaters;
      logic signed [31:0] label_score;
      longint sum;
      longint divisor;
      longint quot;
      wtam_pkg::out_item_t want;
      if (n_buffered < MAX_CLASSES) begin
        class_scores[n_buffered] = it.score;
        n_buffered++;
      end
      if (!it.last_class) return;
      if (it.gt_label < n_buffered && top_k != 0) begin
        label_score = class_scores[it.gt_label];
        beaters = 0;
        for (int c = 0; c < n_buffered; c++) begin
          if (class_scores[c] > label_score ||
              (class_scores[c] == label_score && c > it.gt_label)) beaters++;
        end
        if (beaters < top_k) begin
          sum = weighted_sum + longint'($signed(it.pixel_weight));
          if (sum > SUM_MAX) begin
            sum = SUM_MAX;
            sum_clipped = 1;
          end else if (sum < SUM_MIN) begin
            sum = SUM_MIN;
            sum_clipped = 1;
          end
          weighted_sum = sum;
        end
      end
      n_buffered = 0;
      if (!it.last_pixel) return;
      divisor = (num_images == 0) ? 1 : longint'(num_images);
      quot = weighted_sum / divisor;
      want.saturated = sum_clipped;
      if (quot > longint'(S_MAX)) begin
        quot = S_MAX;
        want.saturated = 1;
      end else if (quot < longint'(S_MIN)) begin
        quot = S_MIN;
        want.saturated = 1;
      end
      want.accuracy = quot[31:0];
      pending_accuracy.insert(pending_accuracy.size(), want);
      weighted_sum = 0;
      sum_clipped = 0;
    endfunction

    function void check_accuracy(wtam_pkg::out_item_t got);
      wtam_pkg::out_item_t want;
      if (pending_accuracy.size() == 0) begin
        $error("unexpected result beat: accuracy %0d", $signed(got.accuracy));
        errors++;
        return;
      end
      want = pending_accuracy.pop_front();
      if (got.accuracy !== want.accuracy) begin
        $error("accuracy: expected %0d, actual %0d",
               $signed(want.accuracy), $signed(got.accuracy));
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  wtam_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wtam_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [wtam_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [wtam_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  topk_accuracy_tracker sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent = 0;
  int pix_scores[$];

  weighted_topk_accuracy_map #(.MAX_CLASSES(MAX_CLASSES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_score(in_data);
      if (out_valid && out_ready) sb.check_accuracy(out_data);
    end
  end

  initial begin
    #(40_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_beat(wtam_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [7:0] label, int weight, bit end_batch);
    wtam_pkg::in_item_t item;
    for (int i = 0; i < pix_scores.size(); i++) begin
      item.score = pix_scores[i];
      if (i == pix_scores.size() - 1) begin
        item.gt_label = label;
        item.pixel_weight = weight;
        item.last_class = 1'b1;
        item.last_pixel = end_batch;
      end else begin
        item.gt_label = 8'($urandom);
        item.pixel_weight = $urandom;
        item.last_class = 1'b0;
        item.last_pixel = 1'($urandom_range(1));
      end
      send_beat(item);
    end
  endtask

  task automatic write_cfg(logic [wtam_pkg::CFG_ADDR_W-1:0] idx, int unsigned val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val[wtam_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // drain all results, let the block settle, then program both registers
  task automatic reconfigure(int unsigned tk, int unsigned ni);
    in_valid = 1'b0;
    while (sb.pending_accuracy.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (HOLD_CYCLES) @(negedge clk);
    write_cfg(wtam_pkg::REG_TOP_K, tk);
    write_cfg(wtam_pkg::REG_NUM_IMAGES, ni);
  endtask

  task automatic random_pixel(bit end_batch);
    int n;
    int pick;
    int mode;
    logic [7:0] label;
    int weight;
    pick = $urandom_range(99);
    if (pick < 70) n = $urandom_range(8, 1);
    else if (pick < 96) n = $urandom_range(40, 9);
    else if (pick < 99) n = $urandom_range(MAX_CLASSES, 41);
    else n = $urandom_range(MAX_CLASSES + 4, MAX_CLASSES + 1);
    mode = $urandom_range(2);
    pix_scores.delete();
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: pix_scores.insert(pix_scores.size(), $urandom);
        1: pix_scores.insert(pix_scores.size(), int'($urandom_range(4)) - 2);
        default: begin
          pick = $urandom_range(3);
          pix_scores.insert(pix_scores.size(),
                            pick == 0 ? S_MIN : pick == 1 ? S_MAX :
                            pick == 2 ? 0 : int'($urandom));
        end
      endcase
    end
    pick = $urandom_range(9);
    if (pick < 8) label = 8'($urandom_range((n > 256 ? 256 : n) - 1));
    else if (pick == 8) label = (n > 256) ? 8'd255 : 8'(n - 1);
    else label = 8'($urandom);
    pick = $urandom_range(3);
    if (pick < 2) weight = $urandom;
    else if (pick == 2) weight = int'($urandom_range(65536 * 4)) - 65536 * 2;
    else weight = $urandom_range(1) ? S_MAX : S_MIN;
    send_pixel(label, weight, end_batch);
  endtask

  initial begin
    int unsigned tk;
    int unsigned ni;
    int pick;
    int goal;
    int n_pix;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    reconfigure(1, 1);
    pix_scores = '{100, 50};
    send_pixel(8'd0, 32'sh0001_0000, 1'b0);
    // equal scores: a larger index beats the label
    pix_scores = '{7, 7, 7};
    send_pixel(8'd2, S_MAX, 1'b0);
    send_pixel(8'd0, S_MAX, 1'b0);
    pix_scores = '{S_MIN, S_MAX};
    send_pixel(8'd1, S_MIN, 1'b1);
    // label past the class count
    pix_scores = '{1, 2};
    send_pixel(8'd255, S_MAX, 1'b1);

    reconfigure(0, 0);
    pix_scores = '{5};
    send_pixel(8'd0, S_MAX, 1'b1);

    reconfigure(256, 0);
    pix_scores = '{S_MAX, S_MAX};
    send_pixel(8'd0, S_MAX, 1'b0);
    pix_scores = '{3};
    send_pixel(8'd0, S_MAX, 1'b1);

    reconfigure(256, 1);
    pix_scores = '{0};
    send_pixel(8'd0, S_MIN, 1'b0);
    send_pixel(8'd0, S_MIN, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 11 : 0;
      goal = beats_sent + 570;
      while (beats_sent < goal) begin
        pick = $urandom_range(9);
        tk = (pick < 3) ? 1 : (pick < 5) ? $urandom_range(4, 2) : (pick == 5) ? 0 :
             (pick == 6) ? 256 : (pick == 7) ? $urandom_range(256, 1) :
             (pick == 8) ? $urandom_range(300, 257) : $urandom_range(20, 5);
        pick = $urandom_range(9);
        ni = (pick < 2) ? 1 : (pick == 2) ? 0 : (pick == 3) ? 65535 :
             (pick < 7) ? $urandom_range(10, 1) : $urandom_range(65535, 1);
        reconfigure(tk, ni);
        for (int b = 0; b < 3; b++) begin
          n_pix = $urandom_range(4, 1);
          for (int p = 0; p < n_pix; p++) random_pixel(p == n_pix - 1);
        end
      end
    end

    // drive the quotient past its upper limit; the last, negative weight does not bring it back below
    reconfigure(1, 1);
    pix_scores = '{0};
    for (int p = 0; p < 4; p++) send_pixel(8'd0, S_MAX, 1'b0);
    send_pixel(8'd0, S_MIN, 1'b1);

    in_valid = 1'b0;
    while (sb.pending_accuracy.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_accuracy.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
